// ----- sv/icer_pkg.sv -----
`timescale 1ns / 1ps
// Package for the ICMP echo reply checker: status codes, byte transaction type,
// ICMP field offsets and sizing constants. No dependencies.
package icer_pkg;

  localparam int unsigned MaxPacketBytesDefault = 2048;
  localparam int unsigned IdentW = 16;

  typedef enum logic [2:0] {
    ST_NOT_REPLY  = 3'd0,
    ST_MISMATCH   = 3'd1,
    ST_GOOD_CSUM  = 3'd2,
    ST_BAD_CSUM   = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_EXP_IDENT = 1'b0,
    CFG_EXP_SEQNO = 1'b1
  } cfg_idx_e;

  // Byte offsets within the ICMP message
  localparam logic [2:0] OffType    = 3'd0;
  localparam logic [2:0] OffCsumHi  = 3'd2;
  localparam logic [2:0] OffCsumLo  = 3'd3;
  localparam logic [2:0] OffIdentHi = 3'd4;
  localparam logic [2:0] OffIdentLo = 3'd5;
  localparam logic [2:0] OffSeqHi   = 3'd6;
  localparam logic [2:0] OffSeqLo   = 3'd7;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } icer_beat_t;

endpackage

// ----- sv/icer_core.sv -----
`timescale 1ns / 1ps
// Per-packet parser and RFC 1071 checksum accumulator; status on the last byte.
// Depends on icer_pkg.
module icer_core #(
  parameter int unsigned MAX_PACKET_BYTES = icer_pkg::MaxPacketBytesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  icer_pkg::icer_beat_t      beat_i,
  input  logic [15:0]               exp_ident_i,
  input  logic [15:0]               exp_seqno_i,
  output icer_pkg::status_e         status_o
);
  import icer_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PACKET_BYTES);
  localparam logic PadOnOverflow = ((MAX_PACKET_BYTES % 2) == 1);

  logic [CntW-1:0] count_q, count_d;
  logic [5:0]      hdr_q, hdr_d;
  logic [7:0]      type_q, type_d;
  logic [15:0]     ident_q, ident_d;
  logic [15:0]     seqno_q, seqno_d;
  logic [15:0]     rxsum_q, rxsum_d;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      pend_q, pend_d;
  logic            ovf_q, ovf_d;

  logic            proc;
  logic [5:0]      h;
  logic [CntW-1:0] h_ext;
  logic            in_icmp;
  logic [CntW-1:0] r;
  logic            r_small;
  logic [7:0]      v;
  logic [CntW-1:0] p_inc;
  logic [CntW-1:0] len;
  logic [CntW-1:0] h_plus8;
  logic            add_en;
  logic [15:0]     add_w;
  logic [16:0]     sum17;
  logic [15:0]     fold;

  always_comb begin
    proc    = beat_i.valid && !ovf_q;
    h       = (count_q == '0) ? {beat_i.data[3:0], 2'b00} : hdr_q;
    h_ext   = CntW'(h);
    in_icmp = proc && (count_q >= h_ext);
    r       = count_q - h_ext;
    r_small = (r[CntW-1:3] == '0);
    p_inc   = count_q + CntW'(1);

    v = beat_i.data;
    if (r_small && (r[2:0] == OffCsumHi || r[2:0] == OffCsumLo)) begin
      v = 8'h00;
    end

    hdr_d   = proc ? h : hdr_q;
    type_d  = type_q;
    ident_d = ident_q;
    seqno_d = seqno_q;
    rxsum_d = rxsum_q;
    if (in_icmp && r_small) begin
      case (r[2:0])
        OffType:    type_d  = beat_i.data;
        OffCsumHi:  rxsum_d = {beat_i.data, 8'h00};
        OffCsumLo:  rxsum_d = {rxsum_q[15:8], beat_i.data};
        OffIdentHi: ident_d = {beat_i.data, 8'h00};
        OffIdentLo: ident_d = {ident_q[15:8], beat_i.data};
        OffSeqHi:   seqno_d = {beat_i.data, 8'h00};
        OffSeqLo:   seqno_d = {seqno_q[15:8], beat_i.data};
        default:    ;
      endcase
    end

    pend_d = pend_q;
    add_en = 1'b0;
    add_w  = 16'h0000;
    if (in_icmp) begin
      if (r[0]) begin
        add_en = 1'b1;
        add_w  = {pend_q, v};
      end else begin
        pend_d = v;
        if (beat_i.last) begin
          add_en = 1'b1;
          add_w  = {v, 8'h00};
        end
      end
    end else if (beat_i.valid && ovf_q && beat_i.last && PadOnOverflow) begin
      add_en = 1'b1;
      add_w  = {pend_q, 8'h00};
    end
    sum17 = {1'b0, sum_q} + {1'b0, add_w};
    fold  = sum17[15:0] + {15'h0000, sum17[16]};
    sum_d = add_en ? fold : sum_q;

    count_d = count_q;
    ovf_d   = ovf_q;
    if (proc) begin
      if (p_inc >= MaxCnt) begin
        ovf_d = 1'b1;
      end else begin
        count_d = p_inc;
      end
    end

    len     = ovf_q ? MaxCnt : p_inc;
    h_plus8 = CntW'(h) + CntW'(8);
    if (len < h_plus8) begin
      status_o = ST_TRUNCATED;
    end else if (type_d != 8'h00) begin
      status_o = ST_NOT_REPLY;
    end else if (ident_d != exp_ident_i || seqno_d != exp_seqno_i) begin
      status_o = ST_MISMATCH;
    end else if (rxsum_d == ~sum_d) begin
      status_o = ST_GOOD_CSUM;
    end else begin
      status_o = ST_BAD_CSUM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hdr_q   <= '0;
      type_q  <= '0;
      ident_q <= '0;
      seqno_q <= '0;
      rxsum_q <= '0;
      sum_q   <= '0;
      pend_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (beat_i.valid) begin
      if (beat_i.last) begin
        count_q <= '0;
        hdr_q   <= '0;
        type_q  <= '0;
        ident_q <= '0;
        seqno_q <= '0;
        rxsum_q <= '0;
        sum_q   <= '0;
        pend_q  <= '0;
        ovf_q   <= 1'b0;
      end else begin
        count_q <= count_d;
        hdr_q   <= hdr_d;
        type_q  <= type_d;
        ident_q <= ident_d;
        seqno_q <= seqno_d;
        rxsum_q <= rxsum_d;
        sum_q   <= sum_d;
        pend_q  <= pend_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// ----- sv/icmp_echo_reply_checker.sv -----
`timescale 1ns / 1ps
// ICMP echo reply checker, top level: stream ports, configuration registers,
// result register. Depends on icer_pkg and icer_core.
//
// Takes one packet byte per clock and gives one status per packet, registered,
// in the cycle after the byte marked tlast is taken. Every byte, the last one too,
// is parsed and summed in the cycle it is taken, so a new packet can start in the
// very next cycle; input is held off only while a status waits to be taken.
// Bytes past MAX_PACKET_BYTES are dropped from the checksum and length count.
// Write expected_ident (index 0) and expected_seqno (index 1) between packets.
module icmp_echo_reply_checker #(
  parameter int unsigned MAX_PACKET_BYTES = icer_pkg::MaxPacketBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] status, [7:3] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import icer_pkg::*;

  logic        s_fire;
  icer_beat_t  beat;
  status_e     status;
  status_e     status_q;
  logic        out_valid_q;
  logic [15:0] exp_ident_q;
  logic [15:0] exp_seqno_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign beat.valid = s_fire;
  assign beat.data  = s_axis_tdata;
  assign beat.last  = s_axis_tlast;

  icer_core #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .exp_ident_i(exp_ident_q),
    .exp_seqno_i(exp_seqno_q),
    .status_o   (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ident_q <= '0;
      exp_seqno_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EXP_IDENT: exp_ident_q <= cfg_data_i;
        CFG_EXP_SEQNO: exp_seqno_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tlast) begin
      status_q <= status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, status_q};

endmodule

// ----- tb/icmp_echo_reply_checker_test.sv -----
`timescale 1ns / 1ps
// Testbench for icmp_echo_reply_checker: byte-stream packets in, one status out per packet.
// A bit-level predictor scores every status but those of pinned probes, with random idling on both sides.
// Depends on icer_pkg and icmp_echo_reply_checker.
module icmp_echo_reply_checker_test;
  import icer_pkg::*;

  localparam int MaxBytes = MaxPacketBytesDefault;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [3:0]  ihl;
    logic [11:0] len;
    logic [7:0]  msg_type;
    logic [15:0] ident;
    logic [15:0] seqno;
    logic        csum_ok;
    logic        pinned;
    status_e     status;
  } probe_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Predictor state, at the widths of the block but for pk_count, which is one bit narrower
  logic [10:0] pk_count;
  logic [5:0]  pk_hdr;
  logic [7:0]  pk_type;
  logic [15:0] pk_ident;
  logic [15:0] pk_seqno;
  logic [15:0] pk_rx_csum;
  logic [15:0] pk_sum;
  logic [7:0]  pk_hi;
  logic        pk_full;
  logic [15:0] want_ident;
  logic [15:0] want_seqno;

  status_e     pending_status_q[$];
  logic [7:0]  frame_q[$];
  int          fail_count;
  int          bytes_sent;
  bit          gaps_on;
  bit          stalls_on;
  bit          long_hold_req;

  probe_t probes [12] = '{
    '{4'd1, 12'd12, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1, ST_GOOD_CSUM},
    '{4'd1, 12'd12, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1, ST_BAD_CSUM},
    '{4'd1, 12'd12, 8'h08, 16'h0000, 16'h0000, 1'b1, 1'b1, ST_NOT_REPLY},
    '{4'd1, 12'd12, 8'h00, 16'h0001, 16'h0000, 1'b1, 1'b1, ST_MISMATCH},
    '{4'd0, 12'd8,  8'h00, 16'h0000, 16'hFFFF, 1'b1, 1'b1, ST_MISMATCH},
    '{4'd1, 12'd11, 8'h08, 16'h0000, 16'h0000, 1'b1, 1'b1, ST_TRUNCATED},
    '{4'd1, 12'd1,  8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1, ST_TRUNCATED},
    '{4'd0, 12'd8,  8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1, ST_GOOD_CSUM},
    '{4'd0, 12'd9,  8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, ST_GOOD_CSUM},
    '{4'd1, 12'd13, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, ST_BAD_CSUM},
    '{4'd15, 12'd68, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1, ST_GOOD_CSUM},
    '{4'd5, 12'd28, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, ST_NOT_REPLY}
  };

  icmp_echo_reply_checker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] fold_add(logic [15:0] acc, logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic note_fail(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  task automatic clear_packet();
    pk_count = '0;
    pk_hdr = '0;
    pk_type = '0;
    pk_ident = '0;
    pk_seqno = '0;
    pk_rx_csum = '0;
    pk_sum = '0;
    pk_hi = '0;
    pk_full = 1'b0;
  endtask

  // Advance the predictor by one accepted byte; queue the status on the last one
  task automatic track_byte(input logic [7:0] b, input logic last, input bit pinned,
                            input status_e pin_status);
    logic [10:0] r;
    logic [7:0]  v;
    logic [11:0] kept;
    logic [11:0] icmp_len;
    status_e     st;
    if (!pk_full) begin
      if (pk_count == 0) pk_hdr = {b[3:0], 2'b00};
      if (pk_count >= 11'(pk_hdr)) begin
        r = pk_count - 11'(pk_hdr);
        v = b;
        if (r < 11'd8) begin
          case (r[2:0])
            OffType:    pk_type = b;
            OffCsumHi:  begin pk_rx_csum = {b, 8'h00}; v = 8'h00; end
            OffCsumLo:  begin pk_rx_csum[7:0] = b; v = 8'h00; end
            OffIdentHi: pk_ident = {b, 8'h00};
            OffIdentLo: pk_ident[7:0] = b;
            OffSeqHi:   pk_seqno = {b, 8'h00};
            OffSeqLo:   pk_seqno[7:0] = b;
            default: ;
          endcase
        end
        if (!r[0]) pk_hi = v;
        else pk_sum = fold_add(pk_sum, {pk_hi, v});
      end
      if (int'(pk_count) + 1 >= MaxBytes) pk_full = 1'b1;
      else pk_count = pk_count + 11'd1;
    end
    if (last) begin
      kept = pk_full ? 12'(MaxBytes) : 12'(pk_count);
      icmp_len = kept - 12'(pk_hdr);
      if (kept > 12'(pk_hdr) && icmp_len[0]) pk_sum = fold_add(pk_sum, {pk_hi, 8'h00});
      if (kept < 12'(pk_hdr) + 12'd8) st = ST_TRUNCATED;
      else if (pk_type != 8'h00) st = ST_NOT_REPLY;
      else if (pk_ident != want_ident || pk_seqno != want_seqno) st = ST_MISMATCH;
      else if (pk_rx_csum == ~pk_sum) st = ST_GOOD_CSUM;
      else st = ST_BAD_CSUM;
      pending_status_q.push_back(pinned ? pin_status : st);
      clear_packet();
    end
  endtask

  // Build an IPv4 packet carrying an ICMP message; checksum over the bytes the block keeps
  task automatic build_frame(input logic [3:0] ihl, input int len, input logic [7:0] msg_type,
                             input logic [15:0] ident, input logic [15:0] seqno, input bit ok);
    int          hb;
    int          kept;
    int          r;
    logic [7:0]  lo;
    logic [15:0] acc;
    logic [15:0] csum;
    hb = int'(ihl) * 4;
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      r = i - hb;
      if (i == 0 && hb != 0) frame_q.push_back({4'($urandom), ihl});
      else if (r == 0) frame_q.push_back(hb == 0 ? {msg_type[7:4], 4'h0} : msg_type);
      else if (r == 2 || r == 3) frame_q.push_back(8'h00);
      else if (r == 4) frame_q.push_back(ident[15:8]);
      else if (r == 5) frame_q.push_back(ident[7:0]);
      else if (r == 6) frame_q.push_back(seqno[15:8]);
      else if (r == 7) frame_q.push_back(seqno[7:0]);
      else frame_q.push_back(8'($urandom));
    end
    kept = (len < MaxBytes) ? len : MaxBytes;
    acc = '0;
    for (int i = hb; i < kept; i += 2) begin
      lo = (i + 1 < kept) ? frame_q[i + 1] : 8'h00;
      if (i - hb != 2) acc = fold_add(acc, {frame_q[i], lo});
    end
    csum = ~acc;
    if (!ok) csum ^= 16'($urandom_range(1, 65535));
    if (hb + 3 < len) begin
      frame_q[hb + 2] = csum[15:8];
      frame_q[hb + 3] = csum[7:0];
    end
  endtask

  task automatic build_random_frame();
    int          k;
    int          hb;
    int          len;
    logic [3:0]  ihl;
    logic [7:0]  msg_type;
    logic [15:0] ident;
    logic [15:0] seqno;
    bit          ok;
    k = $urandom_range(0, 99);
    ihl = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(0, 15));
    hb = int'(ihl) * 4;
    len = hb + 8 + $urandom_range(0, 40);
    msg_type = 8'h00;
    ident = want_ident;
    seqno = want_seqno;
    ok = 1'b1;
    if (k < 8) msg_type = 8'($urandom_range(1, 255));
    else if (k < 14) ident ^= 16'(1 << $urandom_range(0, 15));
    else if (k < 20) seqno = 16'($urandom);
    else if (k < 35) ok = 1'b0;
    else if (k < 45) len = $urandom_range(1, hb + 7);
    if (k >= 45 && k < 53) begin
      frame_q.delete();
      repeat ($urandom_range(1, 48)) frame_q.push_back(8'($urandom));
    end else begin
      build_frame(ihl, len, msg_type, ident, seqno, ok);
    end
  endtask

  task automatic send_frame(input bit pinned, input status_e pin_status);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (gaps_on && $urandom_range(0, 11) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= frame_q[i];
      s_axis_tlast  <= (i == frame_q.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      track_byte(frame_q[i], i == frame_q.size() - 1, pinned, pin_status);
      bytes_sent++;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_expectations(input logic [15:0] ident, input logic [15:0] seqno);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_EXP_IDENT;
    cfg_data_i  <= ident;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_EXP_SEQNO;
    cfg_data_i  <= seqno;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    want_ident = ident;
    want_seqno = seqno;
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    status_e exp_status;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_status_q.size() == 0) begin
        note_fail($sformatf("unexpected status %0d", m_axis_tdata));
      end else begin
        exp_status = pending_status_q.pop_front();
        if (m_axis_tdata !== {5'd0, exp_status})
          note_fail($sformatf("status mismatch: expected %0d, got %0d",
                              exp_status, m_axis_tdata));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("** icmp_echo_reply_checker: FAILED **");
    $finish;
  end

  initial begin
    logic [15:0] ident;
    logic [15:0] seqno;
    int          quota;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_EXP_IDENT;
    cfg_data_i    = 16'h0000;
    fail_count    = 0;
    bytes_sent    = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    long_hold_req = 1'b0;
    want_ident    = 16'h0000;
    want_seqno    = 16'h0000;
    clear_packet();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      build_frame(probes[i].ihl, int'(probes[i].len), probes[i].msg_type, probes[i].ident,
                  probes[i].seqno, probes[i].csum_ok);
      send_frame(probes[i].pinned, probes[i].status);
    end

    bytes_sent = 0;
    for (int phase = 0; phase < 7; phase++) begin
      drain_results();
      case (phase)
        0: begin ident = 16'hFFFF; seqno = 16'hFFFF; end
        1: begin ident = 16'h0000; seqno = 16'hFFFF; end
        3: begin ident = 16'hFFFF; seqno = 16'h0000; end
        default: begin ident = 16'($urandom); seqno = 16'($urandom); end
      endcase
      load_expectations(ident, seqno);
      gaps_on = (phase < 6) && $urandom_range(0, 3) != 0;
      stalls_on = (phase < 6) && $urandom_range(0, 3) != 0;
      if (phase == 2) begin
        // packets around the size limit: bytes past MAX_PACKET_BYTES are dropped
        build_frame(4'd5, MaxBytes - 1, 8'h00, want_ident, want_seqno, 1'b1);
        send_frame(1'b0, ST_GOOD_CSUM);
        build_frame(4'($urandom_range(0, 15)), MaxBytes, 8'h00, want_ident, want_seqno, 1'b1);
        send_frame(1'b0, ST_GOOD_CSUM);
        build_frame(4'd5, MaxBytes + $urandom_range(1, 40), 8'h00, want_ident, want_seqno,
                    $urandom_range(0, 1));
        send_frame(1'b0, ST_GOOD_CSUM);
      end
      if (phase == 3) begin
        gaps_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (25) begin
          build_frame(4'd0, 8, 8'h00, want_ident, want_seqno, 1'b1);
          send_frame(1'b0, ST_GOOD_CSUM);
        end
        drain_results();
      end
      quota = bytes_sent + 160;
      while (bytes_sent < quota) begin
        build_random_frame();
        send_frame(1'b0, ST_GOOD_CSUM);
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (pending_status_q.size() != 0)
      note_fail($sformatf("%0d statuses never arrived", pending_status_q.size()));
    if (fail_count == 0) begin
      $display("** icmp_echo_reply_checker: PASSED **");
    end else begin
      $display("** icmp_echo_reply_checker: FAILED **");
    end
    $finish;
  end

endmodule
